// ===== rtl/delimiter_packet_deframer_unit_macros.svh =====
// Assertion macros shared by the deframer RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef DELIMITER_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define DELIMITER_PACKET_DEFRAMER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ddf_pkg.sv =====
// ----------------------------------------------------------------------------
// ddf_pkg
// Types, register codes and helpers for the delimiter packet deframer.
// ----------------------------------------------------------------------------
package ddf_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 3;
    localparam int PAT_W      = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int LEN_IDX_W  = 2;

    localparam logic [LEN_W-1:0] START_LEN_RST  = 3'd2;
    localparam logic [PAT_W-1:0] START_PAT_RST  = 32'h0000_2A2F;
    localparam logic [LEN_W-1:0] FINISH_LEN_RST = 3'd2;
    localparam logic [PAT_W-1:0] FINISH_PAT_RST = 32'h0000_2F2A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_LEN  = 2'd0,
        CFG_START_PAT  = 2'd1,
        CFG_FINISH_LEN = 2'd2,
        CFG_FINISH_PAT = 2'd3
    } cfg_idx_t;

    // One history byte and whether it arrived since the last clear.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } ddf_link_t;

    // Per-cell compare flags against the incoming byte.
    typedef struct packed {
        logic start;
        logic finish;
    } ddf_hit_t;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic              packet_end;
    } ddf_result_t;

    // Byte j of a delimiter pattern, first byte in bits 7:0.
    function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] pattern,
                                                   input logic [LEN_IDX_W-1:0] j);
        return pattern[{j, 3'b000} +: BYTE_W];
    endfunction

endpackage

// ===== rtl/ddf_byte_if.sv =====
// ----------------------------------------------------------------------------
// ddf_byte_if
// Valid/ready channel carrying one received byte per transfer.
// ----------------------------------------------------------------------------
interface ddf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/ddf_payload_if.sv =====
// ----------------------------------------------------------------------------
// ddf_payload_if
// Valid/ready channel carrying one payload byte and its end-of-packet flag.
// ----------------------------------------------------------------------------
interface ddf_payload_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       packet_end;

    modport source (output valid, output payload_byte, output packet_end, input ready);
    modport sink   (input valid, input payload_byte, input packet_end, output ready);
endinterface

// ===== rtl/ddf_cell.sv =====
// ----------------------------------------------------------------------------
// ddf_cell
// One byte of the delimiter window: holds a history byte, compares the byte
// arriving from its neighbour (or from the input, for the first cell) with its start and finish pattern bytes.
// ----------------------------------------------------------------------------
module ddf_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          shift,
    input  logic                          clear,
    input  ddf_pkg::ddf_link_t            link_in,
    input  logic [ddf_pkg::BYTE_W-1:0]    start_pat,
    input  logic [ddf_pkg::BYTE_W-1:0]    finish_pat,
    output ddf_pkg::ddf_link_t            link_out,
    output ddf_pkg::ddf_hit_t             hit
);
    import ddf_pkg::*;

    ddf_link_t link_reg;
    ddf_link_t link_next;

    // Compare against what this cell will hold after the shift.
    assign hit.start  = link_in.valid && (link_in.data == start_pat);
    assign hit.finish = link_in.valid && (link_in.data == finish_pat);

    always_comb
    begin
        link_next = link_reg;
        if (shift)
        begin
            link_next = clear ? '0 : link_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    assign link_out = link_reg;

endmodule

// ===== rtl/ddf_skid.sv =====
// ----------------------------------------------------------------------------
// ddf_skid
// Output register with a skid entry, so the upstream ready never waits on
// the downstream ready.
// ----------------------------------------------------------------------------
module ddf_skid (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  ddf_pkg::ddf_result_t push_data,
    ddf_payload_if.source        payload_out
);
    import ddf_pkg::*;
    `include "delimiter_packet_deframer_unit_macros.svh"

    logic        out_valid_reg;
    ddf_result_t out_data_reg;
    logic        skid_valid_reg;
    ddf_result_t skid_data_reg;
    logic        push;
    logic        pop;

    assign push_ready = !skid_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop        = out_valid_reg && payload_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_data_reg   <= '0;
            skid_data_reg  <= '0;
        end
        else
        begin
            if (!out_valid_reg || pop)
            begin
                if (skid_valid_reg)
                begin
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                    if (push)
                    begin
                        out_data_reg <= push_data;
                    end
                end
            end
            else if (push)
            begin
                // Output stalled: park the transfer in the skid entry.
                skid_data_reg  <= push_data;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign payload_out.valid        = out_valid_reg;
    assign payload_out.payload_byte = out_data_reg.payload_byte;
    assign payload_out.packet_end   = out_data_reg.packet_end;

    `DDF_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid entry full while output empty")

endmodule

// ===== rtl/delimiter_packet_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// delimiter_packet_deframer_unit
// Start/finish delimiter deframer on a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in takes one received byte per transfer. While hunting, the newest
//   bytes are matched against the start delimiter; inside a packet, payload
//   bytes come out on payload_out, the last one flagged by packet_end when
//   the finish delimiter completes. Delimiter bytes are never passed on and
//   an empty packet yields nothing.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 start
//   length, 1 start pattern, 2 finish length, 3 finish pattern); write only
//   while the block is idle.
//   Throughput: one byte per cycle while byte_in.ready is high. The window is a row of MAX_DELIM_BYTES
//   cells, four at most, that shift and compare in the same cycle.
//   Hold: a payload byte is held once it enters the last finish-window cell;
//   the next transfer passes it on to payload_out via the output register.
//   Stall: the output register plus a skid entry keep byte_in ready while
//   one result waits; with both full, byte_in.ready drops until a transfer.
//   Reset: hunting, window and held byte cleared, registers at "/*" and "*/".
// ----------------------------------------------------------------------------
module delimiter_packet_deframer_unit #(
    parameter int MAX_DELIM_BYTES = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ddf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ddf_pkg::CFG_DATA_W-1:0]  cfg_data,
    ddf_byte_if.sink                        byte_in,
    ddf_payload_if.source                   payload_out
);
    import ddf_pkg::*;
    `include "delimiter_packet_deframer_unit_macros.svh"

    localparam int CAP = (MAX_DELIM_BYTES < 4) ? MAX_DELIM_BYTES : 4;
    localparam int IW  = (CAP > 1) ? $clog2(CAP) : 1;

    logic [LEN_W-1:0] start_length_reg;
    logic [PAT_W-1:0] start_pattern_reg;
    logic [LEN_W-1:0] finish_length_reg;
    logic [PAT_W-1:0] finish_pattern_reg;

    logic              in_packet_reg;
    logic [BYTE_W-1:0] held_byte_reg;
    logic              held_valid_reg;
    logic              in_packet_next;
    logic [BYTE_W-1:0] held_byte_next;
    logic              held_valid_next;

    ddf_link_t          link_in  [CAP];
    ddf_link_t          link_out [CAP];
    ddf_hit_t           hit      [CAP];
    logic [BYTE_W-1:0]  spat     [CAP];
    logic [BYTE_W-1:0]  fpat     [CAP];
    logic [CAP-1:0]     smask;
    logic [CAP-1:0]     fmask;
    logic [CAP-1:0]     shit;
    logic [CAP-1:0]     fhit;

    logic [LEN_IDX_W-1:0] sidx;
    logic [LEN_IDX_W-1:0] fidx;
    logic                 accept;
    logic                 start_match;
    logic                 finish_match;
    logic                 clear;
    logic                 push_valid;
    logic                 push_ready;
    ddf_result_t          push_data;

    // Length to last-byte index, a zero length acting as one and a length above CAP as CAP.
    function automatic logic [LEN_IDX_W-1:0] usable_idx(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] m1;
        m1 = len - 3'd1;
        if (len == '0)
            return '0;
        else if (len > LEN_W'(CAP))
            return LEN_IDX_W'(CAP - 1);
        else
            return m1[LEN_IDX_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_length_reg   <= START_LEN_RST;
            start_pattern_reg  <= START_PAT_RST;
            finish_length_reg  <= FINISH_LEN_RST;
            finish_pattern_reg <= FINISH_PAT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_LEN:  start_length_reg   <= cfg_data[LEN_W-1:0];
                CFG_START_PAT:  start_pattern_reg  <= cfg_data[PAT_W-1:0];
                CFG_FINISH_LEN: finish_length_reg  <= cfg_data[LEN_W-1:0];
                CFG_FINISH_PAT: finish_pattern_reg <= cfg_data[PAT_W-1:0];
            endcase
        end
    end

    assign accept = byte_in.valid && byte_in.ready;
    assign sidx   = usable_idx(start_length_reg);
    assign fidx   = usable_idx(finish_length_reg);

    // Cell k holds the byte received k transfers ago; it meets pattern byte len-1-k.
    always_comb
    begin
        logic [LEN_W-1:0] sdiff;
        logic [LEN_W-1:0] fdiff;
        for (int k = 0; k < CAP; k++)
        begin
            sdiff    = LEN_W'(sidx) - LEN_W'(k);
            fdiff    = LEN_W'(fidx) - LEN_W'(k);
            smask[k] = (LEN_W'(k) <= LEN_W'(sidx));
            fmask[k] = (LEN_W'(k) <= LEN_W'(fidx));
            spat[k]  = pat_byte(start_pattern_reg, sdiff[LEN_IDX_W-1:0]);
            fpat[k]  = pat_byte(finish_pattern_reg, fdiff[LEN_IDX_W-1:0]);
            shit[k]  = hit[k].start;
            fhit[k]  = hit[k].finish;
        end
    end

    assign link_in[0] = '{valid: 1'b1, data: byte_in.rx_byte};

    for (genvar k = 0; k < CAP; k++)
    begin : g_cell
        if (k > 0)
        begin : g_link
            assign link_in[k] = link_out[k-1];
        end
        ddf_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (accept),
            .clear      (clear),
            .link_in    (link_in[k]),
            .start_pat  (spat[k]),
            .finish_pat (fpat[k]),
            .link_out   (link_out[k]),
            .hit        (hit[k])
        );
    end

    // A hit needs a valid byte, so a full match also means the window is filled.
    assign start_match  = &(shit | ~smask);
    assign finish_match = &(fhit | ~fmask);
    assign clear        = in_packet_reg ? finish_match : start_match;

    always_comb
    begin
        in_packet_next  = in_packet_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        push_valid      = 1'b0;
        push_data       = '{payload_byte: held_byte_reg, packet_end: 1'b0};
        if (accept)
        begin
            if (!in_packet_reg)
            begin
                if (start_match)
                begin
                    in_packet_next  = 1'b1;
                    held_valid_next = 1'b0;
                end
            end
            else if (finish_match)
            begin
                push_valid           = held_valid_reg;
                push_data.packet_end = 1'b1;
                in_packet_next       = 1'b0;
                held_valid_next      = 1'b0;
            end
            else
            begin
                push_valid = held_valid_reg;
                // Hold the byte entering the last cell of the finish window.
                if (link_in[fidx[IW-1:0]].valid)
                begin
                    held_byte_next  = link_in[fidx[IW-1:0]].data;
                    held_valid_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg  <= 1'b0;
            held_valid_reg <= 1'b0;
            held_byte_reg  <= '0;
        end
        else
        begin
            in_packet_reg  <= in_packet_next;
            held_valid_reg <= held_valid_next;
            held_byte_reg  <= held_byte_next;
        end
    end

    assign byte_in.ready = push_ready;

    ddf_skid u_skid (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data),
        .payload_out (payload_out)
    );

    `DDF_ASSERT_NOW(a_no_hold_hunting, !in_packet_reg, !held_valid_reg, "held byte while hunting")
    `DDF_ASSERT_NOW(a_push_in_packet, push_valid, in_packet_reg, "result pushed while hunting")
    `DDF_ASSERT_NOW(a_window_contig, link_out[CAP-1].valid, link_out[0].valid, "window valid bits not contiguous")
    `DDF_ASSERT_NEXT(a_finish_to_hunt, accept && in_packet_reg && finish_match, !in_packet_reg && !link_out[0].valid, "finish delimiter did not end packet")

endmodule
